### hw/rtl/pvfg_pkg.sv
// ----------------------------------------------------------------------------
// pvfg_pkg
// Shared types, constants and the sine table function of the vibrato block.
// ----------------------------------------------------------------------------
package pvfg_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int PHASE_BITS_DEF = 16;
    localparam int SINE_DEPTH_DEF = 256;
    localparam int FREQ_BITS_DEF  = 22;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_FREQ = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_FREQ  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIMPLE    = 3'd4;

    localparam logic [2:0] SHAPE_SINE = 3'd0;
    localparam logic [2:0] SHAPE_TRI  = 3'd1;
    localparam logic [2:0] SHAPE_SQR  = 3'd2;
    localparam logic [2:0] SHAPE_UP   = 3'd3;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_WAVE,
        ST_MUL,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic wave;
        logic mul;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_restart;
        logic is_simple;
        logic need_div;
    } t_status;

    // Sine entry k of a table of depth d, Q15.
    function automatic logic signed [16:0] sine_entry(input longint unsigned k,
                                                      input int d);
        logic [63:0] f, quad, r, x, term, sum;
        f = (64'(k) << 32) / 64'(d);
        quad = (f >> 30) & 64'd3;
        r = f & (Q30_ONE - 64'd1);
        if (quad[0]) r = Q30_ONE - r;
        x = (r * HALF_PI_Q30) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 5; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        sum = (sum + 64'd16384) >> 15;
        return (quad >= 64'd2) ? -17'(sum) : 17'(sum);
    endfunction

endpackage

### hw/rtl/pvfg_ctrl.sv
// ----------------------------------------------------------------------------
// pvfg_ctrl
// Sequencer of the vibrato generator: accepts an item, steps the datapath.
// ----------------------------------------------------------------------------
module pvfg_ctrl #(
    parameter int PHASE_BITS = pvfg_pkg::PHASE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pvfg_pkg::t_status i_status,
    output pvfg_pkg::t_cmd    o_cmd
);
    import pvfg_pkg::*;

    localparam int CNT_BITS = $clog2(PHASE_BITS + 1);

    t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt = '0;
                if (i_status.is_restart || i_status.is_simple) n_state = ST_DONE;
                else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.need_div) begin
                    n_state = ST_WAVE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(PHASE_BITS - 1)) n_state = ST_WAVE;
                end
            end
            ST_WAVE: begin
                o_cmd.wave = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    // Accept the next item while handing this one off.
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = ST_PREP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/pvfg_dp.sv
// ----------------------------------------------------------------------------
// pvfg_dp
// Datapath: period state, restoring phase divider, wave shaper, scaling.
// ----------------------------------------------------------------------------
module pvfg_dp #(
    parameter int TIME_BITS  = pvfg_pkg::TIME_BITS_DEF,
    parameter int PHASE_BITS = pvfg_pkg::PHASE_BITS_DEF,
    parameter int SINE_DEPTH = pvfg_pkg::SINE_DEPTH_DEF,
    parameter int FREQ_BITS  = pvfg_pkg::FREQ_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pvfg_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [pvfg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_func,
    input  logic [31:0]                         i_now_time,
    input  pvfg_pkg::t_cmd                      i_cmd,
    output pvfg_pkg::t_status                   o_status,
    output logic [FREQ_BITS-1:0]                o_frequency
);
    import pvfg_pkg::*;

    localparam int IW = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SB = $clog2(SINE_DEPTH);

    function automatic logic signed [16:0] sine_lut(input logic [SB-1:0] a);
        logic signed [16:0] v;
        v = '0;
        for (int k = 0; k < SINE_DEPTH; k++)
            if (a == SB'(k)) v = sine_entry(longint'(k), SINE_DEPTH);
        return v;
    endfunction

    logic [FREQ_BITS-1:0] r_high, r_low;
    logic [IW-1:0]        r_interval;
    logic [2:0]           r_shape;
    logic                 r_simple;
    logic [TIME_BITS-1:0] r_pstart, r_seen;

    logic                 r_func;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS:0]   r_rem;
    logic [PHASE_BITS-1:0] r_q;
    logic                 r_need_div;
    logic [16:0]          r_w;
    logic [FREQ_BITS-1:0] r_res;

    logic [TIME_BITS-1:0] w_int_t, w_start, w_elapsed;
    logic [TIME_BITS:0]   w_sh, w_int_ext;
    logic [31:0]          w_f;
    logic [16:0]          w_tri_r, n_w;
    logic [FREQ_BITS-1:0] w_diff, w_prod;
    logic [FREQ_BITS+16:0] w_mul;
    logic [FREQ_BITS:0]   w_sum;

    assign w_int_t   = TIME_BITS'(r_interval);
    assign w_int_ext = {1'b0, w_int_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high     <= '0;
            r_low      <= '0;
            r_interval <= '0;
            r_shape    <= '0;
            r_simple   <= 1'b0;
            r_pstart   <= '0;
            r_seen     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HIGH_FREQ: r_high     <= FREQ_BITS'({32'd0, i_cfg_data});
                    REG_LOW_FREQ:  r_low      <= FREQ_BITS'({32'd0, i_cfg_data});
                    REG_INTERVAL:  r_interval <= i_cfg_data[IW-1:0];
                    REG_SHAPE:     r_shape    <= i_cfg_data[2:0];
                    REG_SIMPLE:    r_simple   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                if (r_func) begin
                    r_pstart <= r_now;
                end else if (!r_simple) begin
                    r_seen <= w_int_t;
                    if (w_elapsed >= w_int_t) r_pstart <= r_now;
                    else r_pstart <= w_start;
                end
            end
        end
    end

    // Period start after an interval change, then elapsed time.
    assign w_start   = (r_seen != w_int_t) ? r_now : r_pstart;
    assign w_elapsed = r_now - w_start;
    assign w_sh      = {r_rem[TIME_BITS-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_now  <= TIME_BITS'({32'd0, i_now_time});
        end
        if (i_cmd.prep) begin
            r_q <= '0;
            r_rem <= (w_elapsed >= w_int_t) ? '0 : {1'b0, w_elapsed};
            r_need_div <= (w_int_t != '0);
            if (r_func) r_res <= '0;
            else r_res <= FREQ_BITS'((({1'b0, r_high} + {1'b0, r_low}) >> 1));
        end
        if (i_cmd.div_step) begin
            if (w_sh >= w_int_ext) begin
                r_rem <= w_sh - w_int_ext;
                r_q   <= {r_q[PHASE_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[PHASE_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.wave) r_w <= n_w;
        if (i_cmd.mul) r_res <= FREQ_BITS'(w_sum);
    end

    // Wave shaper on the phase as a 32-bit fraction.
    assign w_f = 32'({r_q, 32'd0} >> PHASE_BITS);
    always_comb begin
        w_tri_r = {2'b00, w_f[29:15]};
        if (w_f[30]) w_tri_r = 17'd32768 - w_tri_r;
        case (r_shape)
            SHAPE_SINE: n_w = 17'(sine_lut(w_f[31 -: SB]) + 17'sd32768);
            SHAPE_TRI:  n_w = w_f[31] ? 17'd32768 - w_tri_r : 17'd32768 + w_tri_r;
            SHAPE_SQR:  n_w = w_f[31] ? 17'd0 : 17'd65536;
            SHAPE_UP:   n_w = {1'b0, w_f[31:16]};
            default:    n_w = 17'd65536 - {1'b0, w_f[31:16]};
        endcase
    end

    assign w_diff = (r_high >= r_low) ? r_high - r_low : r_low - r_high;
    assign w_mul  = {17'd0, w_diff} * {{FREQ_BITS{1'b0}}, r_w};
    assign w_prod = w_mul[FREQ_BITS+15:16];
    assign w_sum  = (r_high >= r_low) ? {1'b0, r_low} + {1'b0, w_prod}
                                      : {1'b0, r_low} - {1'b0, w_prod};

    assign o_status.is_restart = r_func;
    assign o_status.is_simple  = r_simple;
    assign o_status.need_div   = r_need_div;
    assign o_frequency = r_res;

endmodule

### hw/rtl/periodic_vibrato_frequency_generator_core.sv
// ----------------------------------------------------------------------------
// periodic_vibrato_frequency_generator_core
// Low-frequency oscillator giving a carrier frequency between two bounds.
// ----------------------------------------------------------------------------
// Usage: an input item (func, now_time) enters on i_in_valid/o_in_ready; one
// result item (frequency) leaves on o_out_valid/i_out_ready per input item.
// A restart item sets the period start and returns zero. A sample item
// returns the frequency for the phase elapsed since the period start.
// Restart and simple-mode items end after PREP; sample items go through PREP,
// the restoring phase divider (DIV) retiring one quotient bit per cycle, WAVE
// and MUL, with no divider step when the interval is zero. The next item is
// accepted in the cycle its predecessor's result is taken. Registers are
// written on i_cfg_we with i_cfg_idx and i_cfg_data while idle; the user must
// keep to this, as the block does not enforce it. Reset clears the config
// registers, the period start and the seen interval. When the receiver
// stalls, the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module periodic_vibrato_frequency_generator_core #(
    parameter int TIME_BITS  = pvfg_pkg::TIME_BITS_DEF,
    parameter int PHASE_BITS = pvfg_pkg::PHASE_BITS_DEF,
    parameter int SINE_DEPTH = pvfg_pkg::SINE_DEPTH_DEF,
    parameter int FREQ_BITS  = pvfg_pkg::FREQ_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pvfg_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [pvfg_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  logic [31:0]                        i_now_time,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [FREQ_BITS-1:0]               o_frequency
);
    import pvfg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pvfg_ctrl #(.PHASE_BITS(PHASE_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    pvfg_dp #(
        .TIME_BITS(TIME_BITS), .PHASE_BITS(PHASE_BITS),
        .SINE_DEPTH(SINE_DEPTH), .FREQ_BITS(FREQ_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_func(i_func), .i_now_time(i_now_time),
        .i_cmd(w_cmd), .o_status(w_status), .o_frequency(o_frequency)
    );

endmodule
